FILE: rtl/tes_pkg.sv
// ----------------------------------------------------------------------------
// Timed event scheduler package
// Shared constants, controller states and the command/status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int SLOT_COUNT_DEF = 4;
  localparam int TIME_BITS_DEF  = 32;

  // most slots fired by one run word
  localparam int MAX_RESULTS = 4;
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // operation codes
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT
  } tes_state_t;

  typedef struct packed {
    logic load;          // capture the accepted word, restart scan and counts
    logic sched_write;   // write the scheduled slot and lower the earliest time
    logic scan_step;     // compare one slot against the best so far
    logic fire;          // clear the best slot and buffer its result
    logic set_earliest;  // record the earliest remaining due time
    logic emit_step;     // advance to the next buffered result
  } tes_cmd_t;

  typedef struct packed {
    logic scan_last;     // scan stands on the last slot
    logic fire_ok;       // best slot is pending, due and the buffer has room
    logic emit_last;     // current result is the final one of the word
  } tes_sts_t;

endpackage

FILE: rtl/tes_ctrl.sv
// ----------------------------------------------------------------------------
// Timed event scheduler controller
// Sequences schedule and run words over the datapath.
// ----------------------------------------------------------------------------
module tes_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  tes_pkg::tes_sts_t sts,
  output tes_pkg::tes_cmd_t cmd,
  output logic              busy,
  output logic              strobe
);

  tes_pkg::tes_state_t state;
  tes_pkg::tes_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tes_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tes_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (operation == tes_pkg::OP_RUN) ? tes_pkg::ST_SCAN
                                                      : tes_pkg::ST_SCHED;
        end
      end
      tes_pkg::ST_SCHED: begin
        state_next = tes_pkg::ST_EMIT;
      end
      tes_pkg::ST_SCAN: begin
        if (sts.scan_last) begin
          state_next = tes_pkg::ST_DECIDE;
        end
      end
      tes_pkg::ST_DECIDE: begin
        state_next = sts.fire_ok ? tes_pkg::ST_SCAN : tes_pkg::ST_EMIT;
      end
      tes_pkg::ST_EMIT: begin
        if (sts.emit_last) begin
          state_next = tes_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tes_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd    = '0;
    busy   = 1'b1;
    strobe = 1'b0;
    unique case (state)
      tes_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      tes_pkg::ST_SCHED: begin
        cmd.sched_write = 1'b1;
      end
      tes_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      tes_pkg::ST_DECIDE: begin
        cmd.fire         = sts.fire_ok;
        cmd.set_earliest = !sts.fire_ok;
      end
      tes_pkg::ST_EMIT: begin
        strobe        = 1'b1;
        cmd.emit_step = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/tes_dp.sv
// ----------------------------------------------------------------------------
// Timed event scheduler datapath
// Slot due times, earliest due time, the slot scan and the result buffer.
// ----------------------------------------------------------------------------
module tes_dp #(
  parameter int SLOT_COUNT = tes_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = tes_pkg::TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  tes_pkg::tes_cmd_t cmd,
  output tes_pkg::tes_sts_t sts,
  input  logic [1:0]        slot_index,
  input  logic [31:0]       now_time,
  input  logic [30:0]       delay_cycles,
  input  logic [31:0]       target_time,
  output logic              fired,
  output logic [1:0]        fired_slot,
  output logic [31:0]       fired_time,
  output logic [31:0]       next_due,
  output logic              last_item
);

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [TIME_BITS-1:0] SIGN = {1'b1, {(TIME_BITS-1){1'b0}}};
  localparam logic [TIME_BITS-1:0] ONE  = TIME_BITS'(1);

  logic [TIME_BITS-1:0] due [SLOT_COUNT];
  logic [TIME_BITS-1:0] earliest;

  // captured word
  logic [TIME_BITS-1:0] sched_sum;
  logic [1:0]           slot_reg;
  logic [TIME_BITS-1:0] target_reg;

  // scan state
  logic [SW-1:0]        scan_idx;
  logic                 best_valid;
  logic [SW-1:0]        best_idx;
  logic [TIME_BITS-1:0] best_key;
  logic [TIME_BITS-1:0] best_due;

  // fired results of the current run word
  logic [SW-1:0]                  buf_slot [tes_pkg::MAX_RESULTS];
  logic [TIME_BITS-1:0]           buf_time [tes_pkg::MAX_RESULTS];
  logic [tes_pkg::RES_CNT_W-1:0]  fire_count;
  logic [tes_pkg::RES_IDX_W-1:0]  emit_idx;

  logic [TIME_BITS-1:0] sched_time;
  logic [TIME_BITS-1:0] earliest_diff;
  logic                 sched_lower;
  logic                 slot_in_range;
  logic [TIME_BITS-1:0] cur_due;
  logic [TIME_BITS-1:0] cur_key;
  logic                 cur_better;
  logic                 best_is_due;

  assign sched_time    = (sched_sum == '0) ? ONE : sched_sum;
  assign earliest_diff = earliest - sched_time;
  assign sched_lower   = (earliest == '0) ||
                         ((earliest_diff != '0) && !earliest_diff[TIME_BITS-1]);
  assign slot_in_range = (32'(slot_reg) < SLOT_COUNT);

  assign cur_due    = due[scan_idx];
  assign cur_key    = (cur_due - target_reg) ^ SIGN;
  assign cur_better = (cur_due != '0) && (!best_valid || (cur_key < best_key));
  // key at or below the sign point means due minus target is zero or negative
  assign best_is_due = (best_key <= SIGN);

  assign sts.scan_last = (scan_idx == SW'(SLOT_COUNT - 1));
  assign sts.fire_ok   = best_valid && best_is_due &&
                         (fire_count < tes_pkg::RES_CNT_W'(tes_pkg::MAX_RESULTS));
  assign sts.emit_last = (fire_count == '0) ||
                         ((tes_pkg::RES_CNT_W'(emit_idx) + 1'b1) == fire_count);

  // capture word, drive the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      best_valid <= 1'b0;
      fire_count <= '0;
      emit_idx   <= '0;
    end else begin
      if (cmd.load || cmd.fire) begin
        scan_idx   <= '0;
        best_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        scan_idx <= sts.scan_last ? '0 : scan_idx + 1'b1;
        if (cur_better) begin
          best_valid <= 1'b1;
        end
      end
      if (cmd.load) begin
        fire_count <= '0;
        emit_idx   <= '0;
      end else begin
        if (cmd.fire) begin
          fire_count <= fire_count + 1'b1;
        end
        if (cmd.emit_step) begin
          emit_idx <= emit_idx + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sched_sum  <= TIME_BITS'(now_time) + TIME_BITS'(delay_cycles);
      slot_reg   <= slot_index;
      target_reg <= TIME_BITS'(target_time);
    end
    if (cmd.scan_step && cur_better) begin
      best_idx <= scan_idx;
      best_key <= cur_key;
      best_due <= cur_due;
    end
    if (cmd.fire) begin
      buf_slot[fire_count[tes_pkg::RES_IDX_W-1:0]] <= best_idx;
      buf_time[fire_count[tes_pkg::RES_IDX_W-1:0]] <= best_due;
    end
  end

  // slot due times and earliest due time
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        due[i] <= '0;
      end
      earliest <= '0;
    end else begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (cmd.sched_write && slot_in_range && (32'(slot_reg) == i)) begin
          due[i] <= sched_time;
        end else if (cmd.fire && (32'(best_idx) == i)) begin
          due[i] <= '0;
        end
      end
      if (cmd.sched_write && slot_in_range && sched_lower) begin
        earliest <= sched_time;
      end else if (cmd.set_earliest) begin
        earliest <= best_valid ? best_due : '0;
      end
    end
  end

  assign fired      = (fire_count != '0);
  assign fired_slot = fired ? 2'(buf_slot[emit_idx]) : 2'd0;
  assign fired_time = fired ? 32'(buf_time[emit_idx]) : 32'd0;
  assign next_due   = 32'(earliest);
  assign last_item  = sts.emit_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fire_count <= tes_pkg::RES_CNT_W'(tes_pkg::MAX_RESULTS))
    else $error("fire count exceeds result buffer");

  a_fire_needs_best: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |-> best_valid && best_is_due)
    else $error("slot fired without a due candidate");

  a_fire_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.fire |=> due[$past(best_idx)] == '0)
    else $error("fired slot still pending");

  a_earliest_pending: assert property (@(posedge clk) disable iff (rst)
    cmd.set_earliest && best_valid |=> earliest != '0)
    else $error("earliest time lost with a slot still pending");

endmodule

FILE: rtl/timed_event_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Timed event scheduler unit
// Keeps a due time for each event slot, schedules slots and fires every slot
// due by a target time, reporting each fired slot as a result word.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake            Fields
//  --------  -------------------  -------------------------------------------
//  input     start && !busy       operation, slot_index, now_time,
//                                 delay_cycles, target_time
//  result    strobe (one cycle)   fired, fired_slot, fired_time, next_due,
//                                 last_item
//
//  Schedule word: busy after acceptance while it writes the slot and then
//  shows the result; the next word is taken on the cycle after the result.
//  Run word: scan and decide repeat for each fired slot and once more, then
//  one result per fired slot, or one if none fired. One shared compare walks
//  the slots one per cycle for each pick, so the scan sets the run time.
//  Reset clears all slots and the earliest due time at once.
//  Results cannot be stalled: each one stands for exactly one cycle.
//
module timed_event_scheduler_unit #(
  parameter int SLOT_COUNT = tes_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = tes_pkg::TIME_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        operation,
  input  logic [1:0]  slot_index,
  input  logic [31:0] now_time,
  input  logic [30:0] delay_cycles,
  input  logic [31:0] target_time,
  output logic        strobe,
  output logic        fired,
  output logic [1:0]  fired_slot,
  output logic [31:0] fired_time,
  output logic [31:0] next_due,
  output logic        last_item
);

  tes_pkg::tes_cmd_t cmd;
  tes_pkg::tes_sts_t sts;

  // sequence the word: capture, schedule or scan/fire, then emit results
  tes_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (operation),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe)
  );

  // hold slot times, scan for the oldest pending slot, buffer fired results
  tes_dp #(
    .SLOT_COUNT (SLOT_COUNT),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .slot_index   (slot_index),
    .now_time     (now_time),
    .delay_cycles (delay_cycles),
    .target_time  (target_time),
    .fired        (fired),
    .fired_slot   (fired_slot),
    .fired_time   (fired_time),
    .next_due     (next_due),
    .last_item    (last_item)
  );

endmodule

FILE: tb/tb_timed_event_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Timed event scheduler unit testbench
// Drives schedule and run words into the scheduler and predicts the result
// word from a model of the slot due times and the earliest due time. A short
// table of directed words walks the wrap, tie and zero-time corners first.
// Random words follow: most of them track a moving current time, and the rest
// are unconstrained noise.
// ----------------------------------------------------------------------------
module tb_timed_event_scheduler_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS           = tes_pkg::SLOT_COUNT_DEF;
  localparam int DIRECTED_COUNT  = 23;
  localparam int RANDOM_WORDS    = 400;
  // no sender idling over the tail of the run
  localparam int QUIET_TAIL      = 60;
  // covers the longest run word: five scans plus four result words
  localparam int SETTLE_CYCLES   = 40;

  typedef struct packed {
    logic        op;
    logic [1:0]  slot;
    logic [31:0] now;
    logic [30:0] delay;
    logic [31:0] target;
  } sched_word_t;

  typedef struct packed {
    logic        fired;
    logic [1:0]  slot;
    logic [31:0] due;
    logic [31:0] next_due;
    logic        last;
  } fire_report_t;

  // one directed word; want is used only where has_want is set
  typedef struct packed {
    sched_word_t  word;
    logic         has_want;
    fire_report_t want;
  } stim_row_t;

  localparam fire_report_t NO_WANT   = '0;
  localparam fire_report_t IDLE_LAST = '{1'b0, 2'd0, 32'd0, 32'd0, 1'b1};

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        start        = 1'b0;
  logic        operation    = tes_pkg::OP_SCHEDULE;
  logic [1:0]  slot_index   = '0;
  logic [31:0] now_time     = '0;
  logic [30:0] delay_cycles = '0;
  logic [31:0] target_time  = '0;
  logic        busy;
  logic        strobe;
  logic        fired;
  logic [1:0]  fired_slot;
  logic [31:0] fired_time;
  logic [31:0] next_due;
  logic        last_item;

  // predictor state: one due time per slot, plus the earliest pending time
  logic [31:0]  model_due [SLOTS];
  logic [31:0]  model_soonest;
  // reports of the word just accepted, and every report still to arrive
  fire_report_t word_reports[$];
  fire_report_t expected_reports[$];
  int           mismatches = 0;

  // Corners: zero time replaced by one, full-range times, the most negative
  // difference firing first, ties going to the lower slot, four slots firing
  // in one run, and a reschedule to a later time that keeps the earliest time.
  stim_row_t directed_rows [DIRECTED_COUNT] = '{
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h0000_0000}, 1'b1, IDLE_LAST},
    '{'{tes_pkg::OP_RUN, 2'd3, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF}, 1'b1, IDLE_LAST},
    '{'{tes_pkg::OP_SCHEDULE, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h0000_0000}, 1'b1,
      '{1'b0, 2'd0, 32'd0, 32'd1, 1'b1}},
    '{'{tes_pkg::OP_SCHEDULE, 2'd1, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'h0000_0000}, 1'b1,
      '{1'b0, 2'd0, 32'd0, 32'd1, 1'b1}},
    '{'{tes_pkg::OP_SCHEDULE, 2'd2, 32'h8000_0000, 31'h0000_0000, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd3, 32'hFFFF_FFFF, 31'h0000_0001, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h0000_0001}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h7FFF_FFFD}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h7FFF_FFFE}, 1'b1,
      '{1'b1, 2'd1, 32'h7FFF_FFFE, 32'd0, 1'b1}},
    '{'{tes_pkg::OP_SCHEDULE, 2'd3, 32'h0000_1000, 31'h0000_0100, 32'h0000_0000}, 1'b1,
      '{1'b0, 2'd0, 32'd0, 32'h0000_1100, 1'b1}},
    '{'{tes_pkg::OP_SCHEDULE, 2'd2, 32'h0000_1000, 31'h0000_0080, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd1, 32'h0000_1000, 31'h0000_0080, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd0, 32'h0000_1000, 31'h0000_0200, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd2, 32'h0000_1000, 31'h0000_0300, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h0000_2000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd0, 32'h7FFF_FFF0, 31'h0000_0020, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd1, 32'h0000_0000, 31'h0000_0010, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h8000_0010}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_SCHEDULE, 2'd3, 32'h5555_5555, 31'h2AAA_AAAA, 32'h0000_0000}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'h2AAA_AAAA}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd0, 32'h0000_0000, 31'h0000_0000, 32'hFFFF_FFFF}, 1'b0, NO_WANT},
    '{'{tes_pkg::OP_RUN, 2'd2, 32'h1234_5678, 31'h0000_0000, 32'h0000_0000}, 1'b1, IDLE_LAST}
  };

  timed_event_scheduler_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .slot_index   (slot_index),
    .now_time     (now_time),
    .delay_cycles (delay_cycles),
    .target_time  (target_time),
    .strobe       (strobe),
    .fired        (fired),
    .fired_slot   (fired_slot),
    .fired_time   (fired_time),
    .next_due     (next_due),
    .last_item    (last_item)
  );

  always #6 clk = ~clk;

  // a later than b on the wrapping time line
  function automatic bit later_than(logic [31:0] a, logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return (diff != 0) && !diff[31];
  endfunction

  // Advance the model by one accepted word and leave its reports in
  // word_reports, in the order the block must emit them.
  function automatic void predict_word(sched_word_t w);
    logic [31:0] due;
    logic [31:0] key;
    logic [31:0] best_key;
    int          best;
    bit          fire_now;
    word_reports.delete();
    best = -1;
    if (w.op == tes_pkg::OP_SCHEDULE) begin
      // zero marks an idle slot, so a zero due time moves to one
      due = w.now + 32'(w.delay);
      if (due == 0) begin
        due = 32'd1;
      end
      model_due[w.slot] = due;
      // only ever lower the earliest time here; a later reschedule keeps it
      if (model_soonest == 0 || later_than(model_soonest, due)) begin
        model_soonest = due;
      end
      word_reports.push_back('{1'b0, 2'd0, 32'd0, 32'd0, 1'b0});
    end else begin
      do begin
        // pick the pending slot with the smallest signed distance to target;
        // flipping the sign bit turns the signed order into an unsigned one
        best     = -1;
        best_key = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (model_due[i] != 0) begin
            key = (model_due[i] - w.target) ^ 32'h8000_0000;
            if (best < 0 || key < best_key) begin
              best     = i;
              best_key = key;
            end
          end
        end
        fire_now = (best >= 0) && !later_than(model_due[best], w.target)
                   && (word_reports.size() < tes_pkg::MAX_RESULTS);
        if (fire_now) begin
          word_reports.push_back('{1'b1, 2'(best), model_due[best], 32'd0, 1'b0});
          model_due[best] = '0;
        end
      end while (fire_now);
      // the last pick is the earliest slot still pending, if any
      model_soonest = (best < 0) ? 32'd0 : model_due[best];
      if (word_reports.size() == 0) begin
        word_reports.push_back('{1'b0, 2'd0, 32'd0, 32'd0, 1'b0});
      end
    end
    foreach (word_reports[k]) begin
      word_reports[k].next_due = model_soonest;
    end
    word_reports[word_reports.size() - 1].last = 1'b1;
  endfunction

  // Hold the word on the inputs until the block takes it, then queue what it
  // must produce. Call only at a rising edge; start stays high on return.
  task automatic issue_word(stim_row_t row);
    start        <= 1'b1;
    operation    <= row.word.op;
    slot_index   <= row.word.slot;
    now_time     <= row.word.now;
    delay_cycles <= row.word.delay;
    target_time  <= row.word.target;
    do @(posedge clk); while (busy !== 1'b0);
    predict_word(row.word);
    if (row.has_want) begin
      expected_reports.push_back(row.want);
    end else begin
      foreach (word_reports[k]) begin
        expected_reports.push_back(word_reports[k]);
      end
    end
  endtask

  // drop start for a random burst, now and then
  task automatic sender_gap(bit allowed);
    if (allowed && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      mismatches++;
    end
  endfunction

  // Results cannot be held off: take every strobed word at the edge that
  // ends its cycle and match it against the oldest expectation.
  always @(posedge clk) begin
    fire_report_t want;
    if (!rst && strobe !== 1'b0) begin
      if (expected_reports.size() == 0) begin
        $error("result word with nothing expected: slot %0d time %0h", fired_slot,
               fired_time);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("fired", 32'(want.fired), 32'(fired));
        check_field("fired_slot", 32'(want.slot), 32'(fired_slot));
        check_field("fired_time", want.due, fired_time);
        check_field("next_due", want.next_due, next_due);
        check_field("last_item", 32'(want.last), 32'(last_item));
      end
    end
  end

  initial begin
    sched_word_t w;
    logic [31:0] sim_clock;
    int          pick;
    foreach (model_due[i]) begin
      model_due[i] = '0;
    end
    model_soonest = '0;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (directed_rows[r]) begin
      issue_word(directed_rows[r]);
      sender_gap(1'b1);
    end

    // Random words: mostly schedules against a moving current time and runs
    // that advance it, so slots pile up, tie and fire together; a tenth of
    // the words are pure noise. Now and then pull the clock close to the
    // wrap point.
    sim_clock = $urandom;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 50) begin
        sim_clock = 32'hFFFF_F000 + 32'($urandom_range(0, 2048));
      end
      pick     = $urandom_range(0, 99);
      w.op     = 1'($urandom);
      w.slot   = 2'($urandom);
      w.now    = $urandom;
      w.delay  = 31'($urandom);
      w.target = $urandom;
      if (pick >= 10 && pick < 55) begin
        w.op  = tes_pkg::OP_SCHEDULE;
        w.now = sim_clock;
        case ($urandom_range(0, 3))
          0: begin
            w.delay = 31'($urandom_range(0, 3));
          end
          1: begin
            w.delay = 31'($urandom_range(0, 200));
          end
          2: begin
            w.delay = 31'($urandom_range(0, 5000));
          end
          default: begin
            // keep the full-range delay
          end
        endcase
      end else if (pick >= 55) begin
        w.op = tes_pkg::OP_RUN;
        case ($urandom_range(0, 7))
          0: begin
            // look behind the current time: nothing new should fire
            w.target = sim_clock - 32'($urandom_range(1, 100));
          end
          1: begin
            // jump the clock far ahead or behind
            sim_clock = w.target;
          end
          default: begin
            sim_clock += 32'($urandom_range(0, 150));
            w.target   = sim_clock;
          end
        endcase
      end
      issue_word('{w, 1'b0, NO_WANT});
      if (n == RANDOM_WORDS / 2) begin
        // let the block drain completely before the next word
        start <= 1'b0;
        while (expected_reports.size() != 0) @(posedge clk);
      end else begin
        sender_gap(((n / 40) % 2 == 0) && (n < RANDOM_WORDS - QUIET_TAIL));
      end
    end

    start <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    // watch for stray results past the last expected one
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_reports.size() != 0) begin
      $error("%0d result words never arrived", expected_reports.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: timed_event_scheduler_unit.f
rtl/tes_pkg.sv
rtl/tes_ctrl.sv
rtl/tes_dp.sv
rtl/timed_event_scheduler_unit.sv
tb/tb_timed_event_scheduler_unit.sv
